[rtl/mssd_pkg.sv]
// ----------------------------------------------------------------------------
// mssd_pkg
// Shared types, codes and the segment table of the seven-segment driver.
// ----------------------------------------------------------------------------
package mssd_pkg;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_ACCESS  = 2'd1,
    ST_DISABLED   = 2'd2,
    ST_BAD_FORMAT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_BIN  = 2'd0,
    MODE_DEC  = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_CHAR = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_DIGIT_COUNT     = 3'd0,
    CFG_DISPLAY_MODE    = 3'd1,
    CFG_COMMON_ANODE    = 3'd2,
    CFG_REPEAT_COUNT    = 3'd3,
    CFG_ACCESS_ALLOWED  = 3'd4,
    CFG_DISPLAY_ENABLED = 3'd5
  } cfg_idx_e;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [3:0] digit_count;
    mode_e      display_mode;
    logic       common_anode;
    logic [3:0] repeat_count;
    logic       access_allowed;
    logic       display_enabled;
  } cfg_t;

  typedef struct packed {
    status_e    status;
    mode_e      mode;
    logic       inv;
    logic [2:0] ndig_m1;
    logic [2:0] rep_m1;
  } ctrl_t;

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'h0: s = 8'h3F;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5B;
      4'h3: s = 8'h4F;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6D;
      4'h6: s = 8'h7D;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7F;
      4'h9: s = 8'h6F;
      4'hA: s = 8'h77;
      4'hB: s = 8'h7C;
      4'hC: s = 8'h39;
      4'hD: s = 8'h5E;
      4'hE: s = 8'h79;
      default: s = 8'h71;
    endcase
    return s;
  endfunction

endpackage

[rtl/mssd_check.sv]
// ----------------------------------------------------------------------------
// mssd_check
// Input stage: access, enable and format checks, repeat clamp, value prep.
// ----------------------------------------------------------------------------
module mssd_check import mssd_pkg::*; #(
  parameter int MAX_DIGITS  = 8,
  parameter int MAX_REPEATS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] value_i,
  output logic        valid_o,
  input  logic        ready_i,
  output ctrl_t       ctrl_o,
  output logic [31:0] value_o
);

  logic        valid_q;
  ctrl_t       ctrl_d, ctrl_q;
  logic [31:0] value_d, value_q;
  logic [7:0]  ch;
  logic        bad_fmt;
  logic [3:0]  reps;

  assign ready_o = !valid_q || ready_i;
  assign ch      = value_i[7:0];

  always_comb begin
    if (cfg_i.display_mode == MODE_CHAR) begin
      bad_fmt = (ch < ASCII_ZERO) || (ch > ASCII_NINE) || (cfg_i.digit_count != 4'd1);
    end else begin
      bad_fmt = (cfg_i.digit_count == 4'd0) ||
                (32'(cfg_i.digit_count) > 32'(MAX_DIGITS));
    end

    if (cfg_i.repeat_count == 4'd0) begin
      reps = 4'd1;
    end else if (32'(cfg_i.repeat_count) > 32'(MAX_REPEATS)) begin
      reps = 4'(MAX_REPEATS);
    end else begin
      reps = cfg_i.repeat_count;
    end

    ctrl_d.mode    = cfg_i.display_mode;
    ctrl_d.inv     = cfg_i.common_anode;
    ctrl_d.ndig_m1 = 3'(cfg_i.digit_count - 4'd1);
    ctrl_d.rep_m1  = 3'(reps - 4'd1);
    if (!cfg_i.access_allowed) begin
      ctrl_d.status = ST_NO_ACCESS;
    end else if (!cfg_i.display_enabled) begin
      ctrl_d.status = ST_DISABLED;
    end else if (bad_fmt) begin
      ctrl_d.status = ST_BAD_FORMAT;
    end else begin
      ctrl_d.status = ST_OK;
    end
    if (ctrl_d.status != ST_OK) begin
      ctrl_d.ndig_m1 = 3'd0;
      ctrl_d.rep_m1  = 3'd0;
    end

    if (cfg_i.display_mode == MODE_CHAR) begin
      value_d = {24'd0, ch - ASCII_ZERO};
    end else begin
      value_d = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctrl_q  <= ctrl_d;
      value_q <= value_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign value_o = value_q;

endmodule

[rtl/mssd_digit_stage.sv]
// ----------------------------------------------------------------------------
// mssd_digit_stage
// One pipeline stage: peels off digit IDX in the item's base.
// ----------------------------------------------------------------------------
module mssd_digit_stage import mssd_pkg::*; #(
  parameter int MAX_DIGITS = 8,
  parameter int IDX        = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  ctrl_t                       ctrl_i,
  input  logic [31:0]                 value_i,
  input  logic [MAX_DIGITS-1:0][3:0]  digits_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output ctrl_t                       ctrl_o,
  output logic [31:0]                 value_o,
  output logic [MAX_DIGITS-1:0][3:0]  digits_o
);

  logic                       valid_q;
  ctrl_t                      ctrl_q;
  logic [31:0]                value_d, value_q;
  logic [MAX_DIGITS-1:0][3:0] digits_d, digits_q;
  logic [63:0]                prod;
  logic [28:0]                quot;
  logic [3:0]                 digit;

  assign ready_o = !valid_q || ready_i;

  // divide by ten through the reciprocal
  assign prod = 64'(value_i) * 64'(DIV10_MAGIC);
  assign quot = prod[63:35];

  always_comb begin
    case (ctrl_i.mode)
      MODE_BIN: begin
        digit   = {3'd0, value_i[0]};
        value_d = {1'b0, value_i[31:1]};
      end
      MODE_HEX: begin
        digit   = value_i[3:0];
        value_d = {4'd0, value_i[31:4]};
      end
      default: begin
        digit   = value_i[3:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};
        value_d = {3'd0, quot};
      end
    endcase
    digits_d      = digits_i;
    digits_d[IDX] = digit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctrl_q   <= ctrl_i;
      value_q  <= value_d;
      digits_q <= digits_d;
    end
  end

  assign valid_o  = valid_q;
  assign ctrl_o   = ctrl_q;
  assign value_o  = value_q;
  assign digits_o = digits_q;

endmodule

[rtl/mssd_scan.sv]
// ----------------------------------------------------------------------------
// mssd_scan
// Scan sequencer: walks digits MSB first over all repeats into the output
// register.
// ----------------------------------------------------------------------------
module mssd_scan import mssd_pkg::*; #(
  parameter int MAX_DIGITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  ctrl_t                       ctrl_i,
  input  logic [MAX_DIGITS-1:0][3:0]  digits_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [2:0]                  digit_select_o,
  output logic [7:0]                  segments_o,
  output logic                        last_o
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic                       busy_q, busy_d;
  ctrl_t                      ctrl_q;
  logic [MAX_DIGITS-1:0][3:0] digits_q;
  logic [2:0]                 pos_q, pos_d;
  logic [2:0]                 rep_q, rep_d;
  logic                       out_valid_q;
  logic [1:0]                 status_q;
  logic [2:0]                 dsel_q;
  logic [7:0]                 seg_q, seg_d;
  logic                       last_q;
  logic                       out_free, emit, last_now, load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = busy_q && out_free;
  assign last_now = (rep_q == 3'd0) && (pos_q == 3'd0);
  assign ready_o  = !busy_q || (emit && last_now);
  assign load     = valid_i && ready_o;

  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    rep_d  = rep_q;
    if (emit) begin
      if (pos_q == 3'd0) begin
        if (rep_q == 3'd0) begin
          busy_d = 1'b0;
        end else begin
          rep_d = rep_q - 3'd1;
          pos_d = ctrl_q.ndig_m1;
        end
      end else begin
        pos_d = pos_q - 3'd1;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      pos_d  = ctrl_i.ndig_m1;
      rep_d  = ctrl_i.rep_m1;
    end
  end

  always_comb begin
    if (ctrl_q.status != ST_OK) begin
      seg_d = 8'd0;
    end else begin
      seg_d = seg_code(digits_q[pos_q[IDX_W-1:0]]) ^ {8{ctrl_q.inv}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= 3'd0;
      rep_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      rep_q  <= rep_d;
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ctrl_q   <= ctrl_i;
      digits_q <= digits_i;
    end
    if (emit) begin
      status_q <= ctrl_q.status;
      dsel_q   <= pos_q;
      seg_q    <= seg_d;
      last_q   <= last_now;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign digit_select_o = dsel_q;
  assign segments_o     = seg_q;
  assign last_o         = last_q;

endmodule

[rtl/multiplexed_seven_segment_driver.sv]
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_driver
// Turns 32-bit values into digit-select / segment beats for a multiplexed
// seven-segment display.
// ----------------------------------------------------------------------------
// Each accepted value yields digit_count * repeat_count output beats (one
// beat for an error), MSB digit first, last set on the units digit of the
// final scan. The front end is a pipeline of MAX_DIGITS + 1 stages (checks,
// then one digit per stage, a divide-by-ten multiplier in each) and takes a
// value every cycle unless in_stall_o is raised; the scan sequencer emits one
// beat per cycle while out_stall_i is low and takes the next value on the
// final beat of the current one.
// Configuration writes are always accepted and must only occur when idle.
module multiplexed_seven_segment_driver import mssd_pkg::*; #(
  parameter int MAX_DIGITS  = 8,
  parameter int MAX_REPEATS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [2:0]  digit_select_o,
  output logic [7:0]  segments_o,
  output logic        last_o
);

  cfg_t cfg_q;

  logic                       vld [MAX_DIGITS+1];
  logic                       rdy [MAX_DIGITS+1];
  ctrl_t                      ctrl [MAX_DIGITS+1];
  logic [31:0]                val [MAX_DIGITS+1];
  logic [MAX_DIGITS-1:0][3:0] dig [MAX_DIGITS+1];
  logic                       in_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.digit_count     <= 4'd1;
      cfg_q.display_mode    <= MODE_DEC;
      cfg_q.common_anode    <= 1'b0;
      cfg_q.repeat_count    <= 4'd1;
      cfg_q.access_allowed  <= 1'b0;
      cfg_q.display_enabled <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DIGIT_COUNT:     cfg_q.digit_count     <= cfg_data_i;
        CFG_DISPLAY_MODE:    cfg_q.display_mode    <= mode_e'(cfg_data_i[1:0]);
        CFG_COMMON_ANODE:    cfg_q.common_anode    <= cfg_data_i[0];
        CFG_REPEAT_COUNT:    cfg_q.repeat_count    <= cfg_data_i;
        CFG_ACCESS_ALLOWED:  cfg_q.access_allowed  <= cfg_data_i[0];
        CFG_DISPLAY_ENABLED: cfg_q.display_enabled <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mssd_check #(
    .MAX_DIGITS  (MAX_DIGITS),
    .MAX_REPEATS (MAX_REPEATS)
  ) u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready),
    .value_i (value_i),
    .valid_o (vld[0]),
    .ready_i (rdy[0]),
    .ctrl_o  (ctrl[0]),
    .value_o (val[0])
  );

  assign in_stall_o = !in_ready;
  assign dig[0]     = '0;

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_stage
    mssd_digit_stage #(
      .MAX_DIGITS (MAX_DIGITS),
      .IDX        (k)
    ) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (vld[k]),
      .ready_o  (rdy[k]),
      .ctrl_i   (ctrl[k]),
      .value_i  (val[k]),
      .digits_i (dig[k]),
      .valid_o  (vld[k+1]),
      .ready_i  (rdy[k+1]),
      .ctrl_o   (ctrl[k+1]),
      .value_o  (val[k+1]),
      .digits_o (dig[k+1])
    );
  end

  mssd_scan #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (vld[MAX_DIGITS]),
    .ready_o        (rdy[MAX_DIGITS]),
    .ctrl_i         (ctrl[MAX_DIGITS]),
    .digits_i       (dig[MAX_DIGITS]),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .digit_select_o (digit_select_o),
    .segments_o     (segments_o),
    .last_o         (last_o)
  );

endmodule

[bench/mssd_scan_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssd_scan_checker
// Watches the configuration, value and scan channels of the seven-segment
// driver. Keeps a shadow copy of the registers, predicts the scan beats of
// every accepted value and compares each output beat with the oldest one.
// ----------------------------------------------------------------------------
module mssd_scan_checker import mssd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [2:0]  digit_select_i,
  input  logic [7:0]  segments_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    status_e    status;
    logic [2:0] digit_select;
    logic [7:0] segments;
    logic       last;
  } scan_beat_t;

  localparam logic [7:0] SEG_LUT [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  logic [3:0] digit_count_q;
  mode_e      mode_q;
  logic       anode_q;
  logic [3:0] repeat_q;
  logic       access_q;
  logic       enable_q;

  scan_beat_t scan_q [$];
  scan_beat_t head;
  int         fails;
  int         depth;

  assign fail_count_o = fails;
  assign pending_o    = depth;

  task automatic predict_scan(input logic [31:0] v);
    longint unsigned num;
    longint unsigned base;
    longint unsigned modulus;
    int unsigned     ndig;
    int unsigned     reps;
    logic [3:0]      digs [8];
    logic [7:0]      seg;
    status_e         err;
    scan_beat_t      b;
    ndig = digit_count_q;
    reps = repeat_q;
    num  = v;
    err  = ST_OK;
    if (!access_q) begin
      err = ST_NO_ACCESS;
    end else if (!enable_q) begin
      err = ST_DISABLED;
    end else if (mode_q == MODE_CHAR) begin
      if (v[7:0] < ASCII_ZERO || v[7:0] > ASCII_NINE || ndig != 1) err = ST_BAD_FORMAT;
    end else if (ndig == 0 || ndig > 8) begin
      err = ST_BAD_FORMAT;
    end
    if (err != ST_OK) begin
      b.status       = err;
      b.digit_select = '0;
      b.segments     = '0;
      b.last         = 1'b1;
      scan_q.push_back(b);
      return;
    end
    if (mode_q == MODE_CHAR) begin
      num  = v[7:0] - ASCII_ZERO;
      base = 10;
    end else begin
      base = (mode_q == MODE_BIN) ? 2 : (mode_q == MODE_HEX) ? 16 : 10;
    end
    if (reps == 0) reps = 1;
    if (reps > 8) reps = 8;
    modulus = 1;
    for (int i = 0; i < ndig; i++) modulus = modulus * base;
    num = num % modulus;
    for (int i = 0; i < ndig; i++) begin
      digs[i] = 4'(num % base);
      num = num / base;
    end
    for (int r = 0; r < reps; r++) begin
      for (int p = ndig - 1; p >= 0; p--) begin
        seg = SEG_LUT[digs[p]];
        if (anode_q) seg = ~seg;
        b.status       = ST_OK;
        b.digit_select = 3'(p);
        b.segments     = seg;
        b.last         = (r == reps - 1) && (p == 0);
        scan_q.push_back(b);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= 4'd1;
      mode_q        <= MODE_DEC;
      anode_q       <= 1'b0;
      repeat_q      <= 4'd1;
      access_q      <= 1'b0;
      enable_q      <= 1'b0;
      scan_q.delete();
      fails = 0;
      depth = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (scan_q.size() == 0) begin
          $error("unexpected beat: status %0d digit_select %0d segments %02h last %0b",
                 status_i, digit_select_i, segments_i, last_i);
          fails++;
        end else begin
          head = scan_q.pop_front();
          if (status_i !== head.status) begin
            $error("status: expected %0d, actual %0d", head.status, status_i);
            fails++;
          end
          if (digit_select_i !== head.digit_select) begin
            $error("digit_select: expected %0d, actual %0d", head.digit_select,
                   digit_select_i);
            fails++;
          end
          if (segments_i !== head.segments) begin
            $error("segments: expected %02h, actual %02h", head.segments, segments_i);
            fails++;
          end
          if (last_i !== head.last) begin
            $error("last: expected %0b, actual %0b", head.last, last_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_scan(value_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DIGIT_COUNT:     digit_count_q <= cfg_data_i;
          CFG_DISPLAY_MODE:    mode_q        <= mode_e'(cfg_data_i[1:0]);
          CFG_COMMON_ANODE:    anode_q       <= cfg_data_i[0];
          CFG_REPEAT_COUNT:    repeat_q      <= cfg_data_i;
          CFG_ACCESS_ALLOWED:  access_q      <= cfg_data_i[0];
          CFG_DISPLAY_ENABLED: enable_q      <= cfg_data_i[0];
          default: ;
        endcase
      end
      depth = scan_q.size();
    end
  end

endmodule

[bench/tb_multiplexed_seven_segment_driver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiplexed_seven_segment_driver
// Drives values through the seven-segment driver under a series of register
// settings: directed corner cases first, then random phases with random
// idle beats on the value side and random stalls on the scan side.
// ----------------------------------------------------------------------------
module tb_multiplexed_seven_segment_driver import mssd_pkg::*;;

  localparam int LATENCY   = 11;
  localparam int LIMIT     = 400000;
  localparam int RAND_ITEMS = 107;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [3:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [2:0]  digit_select_o;
  logic [7:0]  segments_o;
  logic        last_o;

  int   fail_count;
  int   pending;
  int   cycle_cnt;
  logic calm;

  multiplexed_seven_segment_driver u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .value_i,
    .out_valid_o, .out_stall_i, .status_o, .digit_select_o, .segments_o, .last_o
  );

  mssd_scan_checker u_scan_chk (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .digit_select_i(digit_select_o), .segments_i(segments_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("multiplexed_seven_segment_driver: mismatch");
    $finish;
  end

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      out_stall_i <= !calm && ($urandom_range(99) < 22);
    end
  end

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [3:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_display(input logic [3:0] dc, input mode_e mode, input logic ca,
                             input logic [3:0] rc, input logic acc, input logic en);
    wait_idle();
    write_reg(CFG_DIGIT_COUNT, dc);
    write_reg(CFG_DISPLAY_MODE, 4'(mode));
    write_reg(CFG_COMMON_ANODE, 4'(ca));
    write_reg(CFG_REPEAT_COUNT, rc);
    write_reg(CFG_ACCESS_ALLOWED, 4'(acc));
    write_reg(CFG_DISPLAY_ENABLED, 4'(en));
    @(posedge clk_i);
  endtask

  task automatic send_value(input logic [31:0] v);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [31:0] pick_value(input mode_e mode);
    logic [31:0] r;
    int          k;
    r = $urandom;
    k = $urandom_range(9);
    if (mode == MODE_CHAR && k < 7) r[7:0] = ASCII_ZERO + 8'($urandom_range(9));
    else if (k == 7) r = $urandom_range(255);
    else if (k == 8) r = (r[0]) ? '1 : '0;
    return r;
  endfunction

  initial begin
    int          sent;
    int          phase;
    int          calm_phase;
    int          n;
    int          k;
    mode_e       mode;
    logic [3:0]  dc;
    logic [3:0]  rc;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    calm        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: no access
    send_value(32'h1234_5678);
    set_display(4'd1, MODE_DEC, 1'b0, 4'd1, 1'b1, 1'b0);
    send_value(32'hFFFF_FFFF);
    // access checked before enable
    set_display(4'd1, MODE_DEC, 1'b0, 4'd1, 1'b0, 1'b1);
    send_value(32'd7);

    set_display(4'd8, MODE_DEC, 1'b0, 4'd1, 1'b1, 1'b1);
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    send_value(32'd12345678);
    send_value(32'd99999999);

    set_display(4'd8, MODE_HEX, 1'b1, 4'd2, 1'b1, 1'b1);
    send_value(32'hFFFF_FFFF);
    send_value(32'h0000_0000);
    send_value(32'h89AB_CDEF);

    // repeat count zero acts as one
    set_display(4'd8, MODE_BIN, 1'b0, 4'd0, 1'b1, 1'b1);
    send_value(32'h0000_00A5);
    send_value(32'hFFFF_FFFF);

    set_display(4'd0, MODE_DEC, 1'b0, 4'd1, 1'b1, 1'b1);
    send_value(32'd42);
    set_display(4'd9, MODE_BIN, 1'b0, 4'd1, 1'b1, 1'b1);
    send_value(32'd42);
    set_display(4'd15, MODE_HEX, 1'b0, 4'd1, 1'b1, 1'b1);
    send_value(32'd42);

    // character mode, repeat count above range clamps
    set_display(4'd1, MODE_CHAR, 1'b0, 4'd15, 1'b1, 1'b1);
    send_value(32'h0000_0030);
    send_value(32'h0000_0039);
    send_value(32'h0000_002F);
    send_value(32'h0000_003A);
    send_value(32'hFFFF_FF35);
    send_value(32'h0000_0000);
    set_display(4'd2, MODE_CHAR, 1'b0, 4'd1, 1'b1, 1'b1);
    send_value(32'h0000_0035);

    set_display(4'd1, MODE_DEC, 1'b1, 4'd8, 1'b1, 1'b1);
    send_value(32'd7);

    sent       = 0;
    phase      = 0;
    calm_phase = $urandom_range(1, 3);
    while (sent < RAND_ITEMS) begin
      mode = mode_e'($urandom_range(3));
      k = $urandom_range(19);
      if (k == 0) dc = 4'd0;
      else if (k == 1) dc = 4'($urandom_range(9, 15));
      else if (mode == MODE_CHAR && k < 17) dc = 4'd1;
      else dc = 4'($urandom_range(1, 8));
      k = $urandom_range(19);
      if (k < 14) rc = 4'($urandom_range(1, 3));
      else if (k < 18) rc = 4'($urandom_range(4, 8));
      else if (k == 18) rc = 4'd0;
      else rc = 4'($urandom_range(9, 15));
      set_display(dc, mode, 1'($urandom_range(1)), rc,
                  $urandom_range(19) != 0, $urandom_range(19) != 0);
      calm = (phase == calm_phase);
      n = calm ? 30 : $urandom_range(8, 20);
      if (n > RAND_ITEMS - sent) n = RAND_ITEMS - sent;
      repeat (n) send_value(pick_value(mode));
      sent += n;
      phase++;
    end

    wait_idle();
    calm = 1'b0;
    repeat (2 * LATENCY + 2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("multiplexed_seven_segment_driver: match");
    end else begin
      $display("multiplexed_seven_segment_driver: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mssd_pkg.sv
rtl/mssd_check.sv
rtl/mssd_digit_stage.sv
rtl/mssd_scan.sv
rtl/multiplexed_seven_segment_driver.sv
bench/mssd_scan_checker.sv
bench/tb_multiplexed_seven_segment_driver.sv
